// ----- src/pfoq_pkg.sv -----
// ----------------------------------------------------------------------------
// pfoq_pkg
// Types and codes shared by the packet forwarder output queue blocks.
// ----------------------------------------------------------------------------
package pfoq_pkg;

  localparam logic [1:0] FUNC_PKT    = 2'd0;
  localparam logic [1:0] FUNC_FINISH = 2'd1;
  localparam logic [1:0] FUNC_ROUTE  = 2'd2;

  localparam logic [2:0] ACT_NONE         = 3'd0;
  localparam logic [2:0] ACT_LOCAL        = 3'd1;
  localparam logic [2:0] ACT_SENT         = 3'd2;
  localparam logic [2:0] ACT_QUEUED       = 3'd3;
  localparam logic [2:0] ACT_DROP_UNREACH = 3'd4;
  localparam logic [2:0] ACT_DROP_FULL    = 3'd5;

  localparam int REG_MY_ADDRESS     = 0;
  localparam int REG_FRAME_CAPACITY = 1;
  localparam int REG_PORTS_IN_USE   = 2;

  // Command classes handed from the front end to the back end.
  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_RESULT = 2'd1;  // result fully decided by front end
  localparam logic [1:0] CMD_FWD    = 2'd2;  // forward to a port
  localparam logic [1:0] CMD_FINISH = 2'd3;  // transmission finished

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  action;
    logic [2:0]  port;
    logic [15:0] tag;
    logic [7:0]  hops;
    logic [15:0] length;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  port;
    logic [15:0] tag;
    logic [7:0]  hops;
    logic [15:0] length;
  } res_t;

endpackage

// ----- src/pfoq_ram.sv -----
// ----------------------------------------------------------------------------
// pfoq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfoq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/pfoq_front.sv -----
// ----------------------------------------------------------------------------
// pfoq_front
// Accepts items, writes or looks up the route table and classifies each item into a
// command for the back end.
// ----------------------------------------------------------------------------
module pfoq_front #(
  parameter int NUM_PORTS  = 8,
  parameter int ADDR_COUNT = 256,
  parameter int RTW        = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  logic [1:0]      in_func,
  input  logic [7:0]      in_dest_addr,
  input  logic [15:0]     in_packet_tag,
  input  logic [7:0]      in_hop_count,
  input  logic [15:0]     in_byte_length,
  input  logic            in_forced_valid,
  input  logic [7:0]      in_forced_port,
  input  logic [2:0]      in_port,
  input  logic [7:0]      in_route_addr,
  input  logic            in_route_valid,
  input  logic [7:0]      my_address,
  input  logic [3:0]      ports_in_use,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output pfoq_pkg::cmd_t  cmd
);

  logic [ADDR_COUNT-1:0] rt_valid_r;
  logic                  st_r, st_nxt;   // 1: item held for the back end
  logic [1:0]            func_r;
  logic [7:0]            dest_r, hops_r;
  logic [15:0]           tag_r, len_r;
  logic                  fsel_r;
  logic [2:0]            fport_r, port_r;
  logic [2:0]            rt_rdata;
  logic                  rt_we, acc;
  logic                  dest_in_tbl, raddr_in_tbl;
  logic [RTW-1:0]        rd_idx, wr_idx;
  logic                  rt_ok;
  logic [8:0]            piu;
  logic [7:0]            nh;

  assign in_full = st_r;
  assign acc     = in_push && !st_r;
  assign dest_in_tbl  = 32'(in_dest_addr) < ADDR_COUNT;
  assign raddr_in_tbl = 32'(in_route_addr) < ADDR_COUNT;
  // Hold the lookup address while the item waits for the back end.
  assign rd_idx = st_r ? RTW'(dest_r) : RTW'(in_dest_addr);
  assign wr_idx = RTW'(in_route_addr);
  assign rt_we  = acc && in_func == pfoq_pkg::FUNC_ROUTE && raddr_in_tbl;
  assign piu = (32'(ports_in_use) > NUM_PORTS) ? 9'(NUM_PORTS) : 9'(ports_in_use);

  pfoq_ram #(.WIDTH(3), .DEPTH(ADDR_COUNT)) u_rt (
    .clk(clk), .we(rt_we), .waddr(wr_idx), .wdata(in_port),
    .raddr(rd_idx), .rdata(rt_rdata)
  );

  logic rtv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_valid_r <= '0;
      st_r       <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (rt_we) begin
        rt_valid_r[wr_idx] <= in_route_valid;
      end
    end
    if (acc) begin
      func_r  <= in_func;
      dest_r  <= in_dest_addr;
      hops_r  <= in_hop_count;
      tag_r   <= in_packet_tag;
      len_r   <= in_byte_length;
      fsel_r  <= in_forced_valid && ({1'b0, in_forced_port} < piu);
      fport_r <= in_forced_port[2:0];
      port_r  <= in_port;
      rtv_r   <= dest_in_tbl && rt_valid_r[rd_idx];
    end
  end

  always_comb begin
    st_nxt = st_r;
    if (acc) begin
      st_nxt = 1'b1;
    end else if (st_r && cmd_ready) begin
      st_nxt = 1'b0;
    end
  end

  assign rt_ok = rtv_r && (32'(rt_rdata) < NUM_PORTS);
  assign nh = (hops_r == 8'hFF) ? 8'hFF : hops_r + 8'd1;
  assign cmd_valid = st_r;

  always_comb begin
    cmd = '0;
    cmd.tag = tag_r;
    cmd.hops = hops_r;
    cmd.length = len_r;
    case (func_r)
      pfoq_pkg::FUNC_PKT: begin
        if (dest_r == my_address) begin
          cmd.cmd = pfoq_pkg::CMD_RESULT;
          cmd.action = pfoq_pkg::ACT_LOCAL;
        end else if (fsel_r) begin
          cmd.cmd = pfoq_pkg::CMD_FWD;
          cmd.port = fport_r;
          cmd.hops = nh;
        end else if (rt_ok) begin
          cmd.cmd = pfoq_pkg::CMD_FWD;
          cmd.port = rt_rdata;
          cmd.hops = nh;
        end else begin
          cmd.cmd = pfoq_pkg::CMD_RESULT;
          cmd.action = pfoq_pkg::ACT_DROP_UNREACH;
        end
      end
      pfoq_pkg::FUNC_FINISH: begin
        cmd.cmd = (32'(port_r) < NUM_PORTS) ? pfoq_pkg::CMD_FINISH : pfoq_pkg::CMD_NONE;
        cmd.port = port_r;
      end
      default: begin
        cmd.cmd = pfoq_pkg::CMD_NONE;
      end
    endcase
    if (cmd.cmd == pfoq_pkg::CMD_NONE) begin
      cmd.port = '0;
      cmd.tag = '0;
      cmd.hops = '0;
      cmd.length = '0;
    end
  end

endmodule

// ----- src/pfoq_back.sv -----
// ----------------------------------------------------------------------------
// pfoq_back
// Carries out commands: port busy tracking and per-port queues in RAM.
// ----------------------------------------------------------------------------
module pfoq_back #(
  parameter int NUM_PORTS   = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int PW          = 3,
  parameter int QW          = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [5:0]      frame_capacity,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  pfoq_pkg::cmd_t  cmd,
  output logic            res_valid,
  input  logic            res_ready,
  output pfoq_pkg::res_t  res
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MW = $clog2(NUM_PORTS * QUEUE_DEPTH);
  localparam int EW = 40;

  logic [NUM_PORTS-1:0] busy_r;
  logic [QW-1:0]        head_r  [NUM_PORTS];
  logic [CW-1:0]        count_r [NUM_PORTS];
  logic                 ov_r;          // output register holds a result
  pfoq_pkg::res_t       res_r;
  logic                 rd_r;          // queue read in flight
  logic [2:0]           rdport_r;
  logic [PW-1:0]        p;
  logic [CW-1:0]        cnt, limit;
  logic [QW-1:0]        hd, slot;
  logic                 go, we;
  logic [MW-1:0]        waddr, raddr;
  logic [EW-1:0]        rdata;
  logic [CW+QW:0]       sum;

  assign p   = PW'(cmd.port);
  assign cnt = count_r[p];
  assign hd  = head_r[p];
  assign limit = (frame_capacity[5] || 32'(frame_capacity) >= QUEUE_DEPTH)
                 ? CW'(QUEUE_DEPTH) : CW'(frame_capacity);
  assign sum  = (CW+QW+1)'(hd) + (CW+QW+1)'(cnt);
  // Head plus count stays below twice the depth: one subtract wraps it.
  assign slot = (32'(sum) >= QUEUE_DEPTH) ? QW'(sum - (CW+QW+1)'(QUEUE_DEPTH)) : QW'(sum);
  // Take a command only when the output register is free and no read pending.
  assign cmd_ready = !ov_r && !rd_r;
  assign go = cmd_valid && cmd_ready;
  assign we = go && cmd.cmd == pfoq_pkg::CMD_FWD && busy_r[p] && cnt < limit;
  assign waddr = MW'(32'(p) * QUEUE_DEPTH + 32'(slot));
  assign raddr = MW'(32'(p) * QUEUE_DEPTH + 32'(hd));

  pfoq_ram #(.WIDTH(EW), .DEPTH(NUM_PORTS * QUEUE_DEPTH)) u_q (
    .clk(clk), .we(we), .waddr(waddr), .wdata({cmd.tag, cmd.hops, cmd.length}),
    .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      ov_r   <= 1'b0;
      rd_r   <= 1'b0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else begin
      if (ov_r && res_ready) begin
        ov_r <= 1'b0;
      end
      if (rd_r) begin
        rd_r <= 1'b0;
        ov_r <= 1'b1;
        res_r <= '{pfoq_pkg::ACT_SENT, rdport_r, rdata[39:24], rdata[23:16], rdata[15:0]};
      end
      if (go) begin
        case (cmd.cmd)
          pfoq_pkg::CMD_RESULT, pfoq_pkg::CMD_NONE: begin
            ov_r  <= 1'b1;
            res_r <= '{cmd.action, cmd.port, cmd.tag, cmd.hops, cmd.length};
          end
          pfoq_pkg::CMD_FWD: begin
            ov_r <= 1'b1;
            if (!busy_r[p]) begin
              busy_r[p] <= 1'b1;
              res_r <= '{pfoq_pkg::ACT_SENT, cmd.port, cmd.tag, cmd.hops, cmd.length};
            end else if (cnt >= limit) begin
              res_r <= '{pfoq_pkg::ACT_DROP_FULL, cmd.port, cmd.tag, cmd.hops, cmd.length};
            end else begin
              count_r[p] <= cnt + CW'(1);
              res_r <= '{pfoq_pkg::ACT_QUEUED, cmd.port, cmd.tag, cmd.hops, cmd.length};
            end
          end
          pfoq_pkg::CMD_FINISH: begin
            if (cnt == '0) begin
              busy_r[p] <= 1'b0;
              ov_r  <= 1'b1;
              res_r <= '0;
            end else begin
              // Pop the head; data arrives next cycle.
              rd_r       <= 1'b1;
              rdport_r   <= cmd.port;
              head_r[p]  <= (32'(hd) == QUEUE_DEPTH - 1) ? QW'(0) : hd + QW'(1);
              count_r[p] <= cnt - CW'(1);
            end
          end
          default: begin
            ov_r <= 1'b1;
            res_r <= '0;
          end
        endcase
      end
    end
  end

  assign res_valid = ov_r;
  assign res = res_r;

endmodule

// ----- src/pfoq_outq.sv -----
// ----------------------------------------------------------------------------
// pfoq_outq
// Two-entry result queue driving the pop side.
// ----------------------------------------------------------------------------
module pfoq_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  pfoq_pkg::res_t wr_data,
  output logic           empty,
  input  logic           pop,
  output pfoq_pkg::res_t rd_data
);

  pfoq_pkg::res_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           w, r;

  assign wr_ready = cnt_r != 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign w = wr_valid && wr_ready;
  assign r = pop && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (w) begin
        wp_r <= !wp_r;
      end
      if (r) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(w) - 2'(r);
    end
    if (w) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ----- src/packet_forwarder_output_queues_unit.sv -----
// ----------------------------------------------------------------------------
// packet_forwarder_output_queues_unit
// Output-queued packet forwarder with route table and per-port queues.
// ----------------------------------------------------------------------------
// Usage: items enter on push/full with func selecting packet arrival,
// transmission finished or route write. Every item yields exactly one
// result on the empty/pop side, in order (action none for route writes).
// Registers my_address, frame_capacity and ports_in_use sit on the APB
// port at byte addresses 0, 4 and 8.
// Path: an accepted item passes the front-end registers, the back-end
// output register and the result queue; a finish that pops a queued
// packet passes a queue RAM read before the output register.
// Flow: the front end holds one item through the route-table read
// and until the back end takes it; a finish that pops a queued packet
// holds the back end during its queue RAM read. A finished result is
// held in a two-entry queue so the block keeps working while the
// receiver stalls; when that queue fills, full rises and the block holds.
// Reset: all routes invalid, ports idle, queues empty; no clearing pass.
// ----------------------------------------------------------------------------
module packet_forwarder_output_queues_unit #(
  parameter int NUM_PORTS   = 8,
  parameter int ADDR_COUNT  = 256,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_dest_addr,
  input  logic [15:0] in_packet_tag,
  input  logic [7:0]  in_hop_count,
  input  logic [15:0] in_byte_length,
  input  logic        in_forced_valid,
  input  logic [7:0]  in_forced_port,
  input  logic [2:0]  in_port,
  input  logic [7:0]  in_route_addr,
  input  logic        in_route_valid,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_action,
  output logic [2:0]  out_out_port,
  output logic [15:0] out_out_tag,
  output logic [7:0]  out_out_hops,
  output logic [15:0] out_out_length
);

  localparam int PW  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int RTW = $clog2(ADDR_COUNT);
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [7:0] my_address_r;
  logic [5:0] frame_capacity_r;
  logic [3:0] ports_in_use_r;
  logic       cfg_we;
  logic [1:0] ridx;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign ridx   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_address_r     <= 8'd0;
      frame_capacity_r <= 6'h3F;
      ports_in_use_r   <= 4'd8;
    end else if (cfg_we) begin
      case (32'(ridx))
        pfoq_pkg::REG_MY_ADDRESS:     my_address_r     <= pwdata[7:0];
        pfoq_pkg::REG_FRAME_CAPACITY: frame_capacity_r <= pwdata[5:0];
        pfoq_pkg::REG_PORTS_IN_USE:   ports_in_use_r   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (32'(ridx))
      pfoq_pkg::REG_MY_ADDRESS:     prdata = {24'd0, my_address_r};
      pfoq_pkg::REG_FRAME_CAPACITY: prdata = {{26{frame_capacity_r[5]}}, frame_capacity_r};
      pfoq_pkg::REG_PORTS_IN_USE:   prdata = {28'd0, ports_in_use_r};
      default:                      prdata = 32'd0;
    endcase
  end

  logic           cmd_valid, cmd_ready, res_valid, res_ready;
  pfoq_pkg::cmd_t cmd;
  pfoq_pkg::res_t res, head;

  pfoq_front #(.NUM_PORTS(NUM_PORTS), .ADDR_COUNT(ADDR_COUNT), .RTW(RTW)) u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_func(in_func), .in_dest_addr(in_dest_addr), .in_packet_tag(in_packet_tag),
    .in_hop_count(in_hop_count), .in_byte_length(in_byte_length),
    .in_forced_valid(in_forced_valid), .in_forced_port(in_forced_port),
    .in_port(in_port), .in_route_addr(in_route_addr), .in_route_valid(in_route_valid),
    .my_address(my_address_r), .ports_in_use(ports_in_use_r),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  pfoq_back #(.NUM_PORTS(NUM_PORTS), .QUEUE_DEPTH(QUEUE_DEPTH), .PW(PW), .QW(QW)) u_back (
    .clk(clk), .rst_n(rst_n), .frame_capacity(frame_capacity_r),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  pfoq_outq u_outq (
    .clk(clk), .rst_n(rst_n), .wr_valid(res_valid), .wr_ready(res_ready),
    .wr_data(res), .empty(out_empty), .pop(out_pop), .rd_data(head)
  );

  assign out_action     = head.action;
  assign out_out_port   = head.port;
  assign out_out_tag    = head.tag;
  assign out_out_hops   = head.hops;
  assign out_out_length = head.length;

endmodule

// ----- src/pfoq_checker.sv -----
// ----------------------------------------------------------------------------
// pfoq_checker
// Port-level checks for the packet forwarder output queue unit.
// ----------------------------------------------------------------------------
module pfoq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_push,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [2:0] out_action,
  input logic [7:0] out_out_hops
);

  // Results never carry an undefined action code.
  a_action: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_action <= pfoq_pkg::ACT_DROP_FULL)
    else $error("bad action code");

  // A waiting result stays until popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_action))
    else $error("result lost while stalled");

  // After reset no result is shown.
  a_rst: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result after reset");

  // An action-none result carries zero hops.
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_action == pfoq_pkg::ACT_NONE |-> out_out_hops == 8'd0)
    else $error("none result not cleared");

  // The front end raises full after accepting a transaction, while it holds the item.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full |=> in_full)
    else $error("full not raised after accept");

endmodule

bind packet_forwarder_output_queues_unit pfoq_checker u_pfoq_checker (
  .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
  .out_empty(out_empty), .out_pop(out_pop), .out_action(out_action),
  .out_out_hops(out_out_hops)
);
